// ===== design/escape_sequence_decoder_defines.svh =====
// Assertion macros used by the checker of the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Checked only while the block is out of reset.
`define ESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ESD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/esd_pkg.sv =====
package esd_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int HEXV_W   = 5;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX1   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX2   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRAIL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADHEX     = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
  localparam logic [CHAR_W-1:0] BYTE_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] BYTE_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] BYTE_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] BYTE_NUL  = 8'h00;

  localparam logic [HEXV_W-1:0] HEX_NONE = 5'd16;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic                valid;
    logic                eos;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [HEXV_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = {{(CHAR_W-HEXV_W){1'b0}}, HEX_NONE};
    end
    return d[HEXV_W-1:0];
  endfunction

endpackage

// ===== design/esd_in_stage.sv =====
module esd_in_stage
  import esd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/esd_decode.sv =====
module esd_decode
  import esd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CHAR_W-1:0] first_r, first_nxt;
  logic              error_r, error_nxt;

  logic [HEXV_W-1:0] hi_v, lo_v;
  logic [3:0]        hi;
  logic              err;

  assign hi_v = hex_value(first_r);
  assign lo_v = hex_value(item.ch);
  assign hi   = (hi_v == HEX_NONE) ? 4'd0 : hi_v[3:0];

  always_comb begin
    result.ch     = '0;
    result.valid  = 1'b0;
    result.eos    = item.last;
    result.status = ST_OK;
    mode_nxt      = mode_r;
    first_nxt     = first_r;
    error_nxt     = error_r;
    err           = 1'b0;
    if (!error_r) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (item.ch == CH_BSLASH) begin
            if (item.last) begin
              result.status = ST_TRAIL;
              err           = 1'b1;
            end else begin
              mode_nxt = MODE_ESC;
            end
          end else begin
            result.ch    = item.ch;
            result.valid = 1'b1;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_NORMAL;
          case (item.ch)
            CH_N:      begin result.ch = BYTE_LF;   result.valid = 1'b1; end
            CH_T:      begin result.ch = BYTE_TAB;  result.valid = 1'b1; end
            CH_R:      begin result.ch = BYTE_CR;   result.valid = 1'b1; end
            CH_SQUOTE: begin result.ch = CH_SQUOTE; result.valid = 1'b1; end
            CH_DQUOTE: begin result.ch = CH_DQUOTE; result.valid = 1'b1; end
            CH_BSLASH: begin result.ch = CH_BSLASH; result.valid = 1'b1; end
            CH_ZERO:   begin result.ch = BYTE_NUL;  result.valid = 1'b1; end
            CH_X: begin
              if (item.last) begin
                result.status = ST_INCOMPLETE;
                err           = 1'b1;
              end else begin
                mode_nxt = MODE_HEX1;
              end
            end
            default: ;
          endcase
        end
        MODE_HEX1: begin
          if (item.last) begin
            result.status = ST_INCOMPLETE;
            err           = 1'b1;
          end else if (lo_v == HEX_NONE) begin
            result.status = ST_BADHEX;
            err           = 1'b1;
          end else begin
            first_nxt = item.ch;
            mode_nxt  = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          result.ch    = (lo_v == HEX_NONE) ? {4'd0, hi} : {hi, lo_v[3:0]};
          result.valid = 1'b1;
          mode_nxt     = MODE_NORMAL;
        end
        default: ;
      endcase
      if (err) begin
        error_nxt = 1'b1;
        mode_nxt  = MODE_NORMAL;
      end
    end
    if (item.last) begin
      mode_nxt  = MODE_NORMAL;
      first_nxt = '0;
      error_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      first_r <= '0;
      error_r <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      first_r <= first_nxt;
      error_r <= error_nxt;
    end
  end

endmodule

// ===== design/esd_out_stage.sv =====
module esd_out_stage
  import esd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  output logic    can_load,
  input  result_t result_in,
  output logic    out_res_valid,
  input  logic    out_res_stall,
  output result_t result_out
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign can_load = !valid_r || !out_res_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_res_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_res_valid = valid_r;
  assign result_out    = result_r;

endmodule

// ===== design/escape_sequence_decoder.sv =====
// Each input character is held in the input register, then decoded and
// registered in the result register, which offers it on the output.
// Throughput: one character per cycle while out_res_stall is low, set by
// the single decode step between the input register and the result register.
// Reset: synchronous and active low; it empties both registers and returns
// the escape mode, the stored hex digit and the error flag to their idle values.
module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAR_W-1:0]   in_char,
  input  logic                in_last_char,
  output logic                out_res_valid,
  input  logic                out_res_stall,
  output logic [CHAR_W-1:0]   out_char,
  output logic                out_valid,
  output logic                out_end_of_string,
  output logic [STATUS_W-1:0] out_status
);

  item_t   in_item, item;
  result_t dec_result, result;
  logic    item_valid, can_load, advance;

  assign in_item.ch   = in_char;
  assign in_item.last = in_last_char;
  assign advance      = item_valid && can_load;

  esd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (dec_result)
  );

  esd_out_stage u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (advance),
    .can_load      (can_load),
    .result_in     (dec_result),
    .out_res_valid (out_res_valid),
    .out_res_stall (out_res_stall),
    .result_out    (result)
  );

  assign out_char          = result.ch;
  assign out_valid         = result.valid;
  assign out_end_of_string = result.eos;
  assign out_status        = result.status;

endmodule

// ===== design/esd_checker.sv =====
`include "escape_sequence_decoder_defines.svh"

module esd_checker
  import esd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_res_valid,
  input logic                out_res_stall,
  input logic [CHAR_W-1:0]   out_char,
  input logic                out_valid,
  input logic                out_end_of_string,
  input logic [STATUS_W-1:0] out_status
);

  logic                       res_held;
  logic                       res_err;
  logic                       res_empty;
  logic                       res_end_err;
  logic [CHAR_W+STATUS_W+1:0] out_bits;

  assign res_held    = out_res_valid && out_res_stall;
  assign res_err     = out_res_valid && out_status != ST_OK;
  assign res_empty   = out_res_valid && !out_valid;
  assign res_end_err = out_res_valid && (out_status == ST_TRAIL || out_status == ST_INCOMPLETE);
  assign out_bits    = {out_char, out_valid, out_end_of_string, out_status};

  `ESD_ASSERT(a_out_hold, res_held |=> out_res_valid && $stable(out_bits), "Stalled result changed.")
  `ESD_ASSERT(a_err_no_byte, res_err |-> !out_valid, "Error result carries a byte.")
  `ESD_ASSERT(a_empty_byte, res_empty |-> out_char == '0, "Empty result has a nonzero byte.")
  `ESD_ASSERT(a_trail_at_end, res_end_err |-> out_end_of_string, "End error away from string end.")
  `ESD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_res_valid && !in_stall, "Not empty after reset.")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);
